// ----- hdl/first_fit_block_allocator_unit_defines.svh -----
// Assertion macros for the first-fit block allocator.
// Included by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define FFBA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("allocator assertion failed");
`define FFBA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("allocator assertion failed");
`else
`define FFBA_ASSERT_IMPL(lbl, ante, cons)
`define FFBA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/ffba_pkg.sv -----
// Shared types for the first-fit block allocator: datapath operations,
// result status codes, register indexes and the controller/datapath structs.
package ffba_pkg;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_SIZE  = 2'd0,
        CFG_BUFFER_SIZE = 2'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_TFULL   = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV_STEP,
        OP_ROUND,
        OP_FRD,
        OP_FADV,
        OP_A_TAKE,
        OP_FWR_SPLIT,
        OP_FRD_MV_UP,
        OP_FWR_MV_DOWN,
        OP_F_DEC,
        OP_FRD_MV_DN,
        OP_FWR_MV_UP,
        OP_F_INS_INIT,
        OP_FWR_NEW,
        OP_EVAL,
        OP_FWR_MERGE,
        OP_URD,
        OP_UADV,
        OP_U_LATCH,
        OP_URD_NEXT,
        OP_UWR_DOWN,
        OP_U_DEC,
        OP_UWR_NEW,
        OP_FIN
    } t_op;

    typedef struct packed {
        t_op     op;
        t_status code;
    } t_cmd;

    typedef struct packed {
        logic is_free;
        logic bsz_zero;
        logic ufull;
        logic div_last;
        logic f_more;
        logic fit;
        logic exact;
        logic le_off;
        logic u_more;
        logic id_eq;
        logic zero_len;
        logic mp;
        logic mn;
        logic ffull;
        logic fmv_more;
        logic fins_more;
        logic umv_more;
    } t_dp_stat;

endpackage

// ----- hdl/ffba_ctrl.sv -----
// Sequencer for the first-fit block allocator.
// Uses ffba_pkg; drives ffba_dp with one command per cycle.
module ffba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ffba_pkg::t_dp_stat i_stat,
    output ffba_pkg::t_cmd    o_cmd,
    output logic              o_busy
);
    import ffba_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_ROUTE, S_DIV, S_ROUND, S_ASCAN, S_ACHK, S_ATAKE, S_UNEW,
        S_USCAN, S_UCHK, S_ZCHK, S_PSCAN, S_PCHK, S_EVAL, S_DECIDE,
        S_FDROP, S_FDROP_W, S_FINS, S_FINS_W, S_UDROP, S_UDROP_W, S_FIN
    } t_state;

    t_state  r_state, n_state;
    t_status r_code, n_code;
    t_op     op;

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        op      = OP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    op      = OP_LOAD;
                    n_state = S_ROUTE;
                end
            end
            S_ROUTE: begin
                if (i_stat.is_free) begin
                    n_state = S_USCAN;
                end else if (i_stat.ufull) begin
                    n_code  = ST_TFULL;
                    n_state = S_FIN;
                end else if (i_stat.bsz_zero) begin
                    n_state = S_ROUND;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                op = OP_DIV_STEP;
                if (i_stat.div_last) n_state = S_ROUND;
            end
            S_ROUND: begin
                op      = OP_ROUND;
                n_state = S_ASCAN;
            end
            S_ASCAN: begin
                if (i_stat.f_more) begin
                    op      = OP_FRD;
                    n_state = S_ACHK;
                end else begin
                    n_code  = ST_OOM;
                    n_state = S_FIN;
                end
            end
            S_ACHK: begin
                if (i_stat.fit) begin
                    op      = OP_A_TAKE;
                    n_state = S_ATAKE;
                end else begin
                    op      = OP_FADV;
                    n_state = S_ASCAN;
                end
            end
            S_ATAKE: begin
                if (i_stat.exact) begin
                    n_state = S_FDROP;
                end else begin
                    op      = OP_FWR_SPLIT;
                    n_state = S_UNEW;
                end
            end
            S_UNEW: begin
                op      = OP_UWR_NEW;
                n_code  = ST_OK;
                n_state = S_FIN;
            end
            S_USCAN: begin
                if (i_stat.u_more) begin
                    op      = OP_URD;
                    n_state = S_UCHK;
                end else begin
                    n_code  = ST_UNKNOWN;
                    n_state = S_FIN;
                end
            end
            S_UCHK: begin
                if (i_stat.id_eq) begin
                    op      = OP_U_LATCH;
                    n_state = S_ZCHK;
                end else begin
                    op      = OP_UADV;
                    n_state = S_USCAN;
                end
            end
            S_ZCHK: begin
                n_state = i_stat.zero_len ? S_UDROP : S_PSCAN;
            end
            S_PSCAN: begin
                if (i_stat.f_more) begin
                    op      = OP_FRD;
                    n_state = S_PCHK;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_PCHK: begin
                if (i_stat.le_off) begin
                    op      = OP_FADV;
                    n_state = S_PSCAN;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                op      = OP_EVAL;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (!i_stat.mp && !i_stat.mn && i_stat.ffull) begin
                    n_code  = ST_TFULL;
                    n_state = S_FIN;
                end else if (i_stat.mp || i_stat.mn) begin
                    op      = OP_FWR_MERGE;
                    n_state = (i_stat.mp && i_stat.mn) ? S_FDROP : S_UDROP;
                end else begin
                    op      = OP_F_INS_INIT;
                    n_state = S_FINS;
                end
            end
            S_FDROP: begin
                if (i_stat.fmv_more) begin
                    op      = OP_FRD_MV_UP;
                    n_state = S_FDROP_W;
                end else begin
                    op      = OP_F_DEC;
                    n_state = i_stat.is_free ? S_UDROP : S_UNEW;
                end
            end
            S_FDROP_W: begin
                op      = OP_FWR_MV_DOWN;
                n_state = S_FDROP;
            end
            S_FINS: begin
                if (i_stat.fins_more) begin
                    op      = OP_FRD_MV_DN;
                    n_state = S_FINS_W;
                end else begin
                    op      = OP_FWR_NEW;
                    n_state = S_UDROP;
                end
            end
            S_FINS_W: begin
                op      = OP_FWR_MV_UP;
                n_state = S_FINS;
            end
            S_UDROP: begin
                if (i_stat.umv_more) begin
                    op      = OP_URD_NEXT;
                    n_state = S_UDROP_W;
                end else begin
                    op      = OP_U_DEC;
                    n_code  = ST_OK;
                    n_state = S_FIN;
                end
            end
            S_UDROP_W: begin
                op      = OP_UWR_DOWN;
                n_state = S_UDROP;
            end
            S_FIN: begin
                op      = OP_FIN;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    assign o_cmd.op   = op;
    assign o_cmd.code = r_code;
    assign o_busy     = (r_state != S_IDLE);

endmodule

// ----- hdl/ffba_dp.sv -----
// Datapath of the first-fit block allocator: free-range and allocation
// memories, remainder unit, pointers, totals and result registers. Uses ffba_pkg.
module ffba_dp #(
    parameter int FREE_SLOTS = 32,
    parameter int USED_SLOTS = 32,
    parameter int ADDR_BITS  = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ffba_pkg::t_cmd                 i_cmd,
    output ffba_pkg::t_dp_stat             o_stat,
    input  logic                           i_mode,
    input  logic [31:0]                    i_req_size,
    input  logic [31:0]                    i_alloc_id,
    input  logic                           i_cfg_we,
    input  logic [ffba_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    output logic                           o_done,
    output logic [1:0]                     o_status,
    output logic [31:0]                    o_grant_id,
    output logic [31:0]                    o_grant_offset,
    output logic [31:0]                    o_grant_size,
    output logic [31:0]                    o_free_bytes,
    output logic [31:0]                    o_used_bytes,
    output logic [5:0]                     o_used_count,
    output logic [5:0]                     o_free_count
);
    import ffba_pkg::*;

    localparam int AW  = ADDR_BITS;
    localparam int CW  = (ADDR_BITS > 33) ? ADDR_BITS : 33;
    localparam int FCW = $clog2(FREE_SLOTS + 1);
    localparam int FIW = $clog2(FREE_SLOTS);
    localparam int UCW = $clog2(USED_SLOTS + 1);
    localparam int UIW = (USED_SLOTS > 1) ? $clog2(USED_SLOTS) : 1;
    localparam logic [FCW-1:0] F_MAX = FCW'(FREE_SLOTS);
    localparam logic [UCW-1:0] U_MAX = UCW'(USED_SLOTS);

    // memories
    logic [AW-1:0] fb_mem [FREE_SLOTS];
    logic [AW-1:0] fl_mem [FREE_SLOTS];
    logic [31:0]   uid_mem [USED_SLOTS];
    logic [AW-1:0] ub_mem [USED_SLOTS];
    logic [AW-1:0] ul_mem [USED_SLOTS];

    // control state
    logic [15:0]    r_bsz;
    logic [FCW-1:0] r_fcnt;
    logic [UCW-1:0] r_ucnt;
    logic [31:0]    r_next_id;
    logic [31:0]    r_ftot;
    logic [31:0]    r_utot;
    logic           r_done;

    // working registers
    logic           r_mode;
    logic [31:0]    r_req;
    logic [31:0]    r_id;
    logic [31:0]    r_dsh;
    logic [15:0]    r_rem;
    logic [4:0]     r_dcnt;
    logic [32:0]    r_real;
    logic [FCW-1:0] r_fp;
    logic [FCW-1:0] r_fm;
    logic [UCW-1:0] r_up;
    logic [AW-1:0]  r_fb, r_fl, r_pb, r_pl, r_goff, r_off, r_len;
    logic [31:0]    r_uid;
    logic [AW-1:0]  r_ub, r_ul;
    logic           r_mp, r_mn;
    logic [1:0]     r_status;
    logic [31:0]    r_gid, r_goffs, r_gsz;

    // derived values
    logic [FCW:0]   fm_inc;
    logic [FCW-1:0] fm_dec;
    logic [FCW-1:0] fp_dec;
    logic [UCW:0]   up_inc;
    logic [16:0]    div_t;
    logic           div_ge;
    logic [AW:0]    prev_end;
    logic [AW:0]    cur_end;
    logic           ok;
    logic [31:0]    n_ftot, n_utot;
    logic [AW-1:0]  cfg_buf;

    // memory port controls
    logic           f_we, f_re;
    logic [FIW-1:0] f_waddr, f_raddr;
    logic [AW-1:0]  f_wb, f_wl;
    logic           u_we, u_re;
    logic [UIW-1:0] u_waddr, u_raddr;
    logic [31:0]    u_wid;
    logic [AW-1:0]  u_wb, u_wl;

    assign fm_inc   = (FCW+1)'(r_fm) + (FCW+1)'(1);
    assign fm_dec   = r_fm - FCW'(1);
    assign fp_dec   = r_fp - FCW'(1);
    assign up_inc   = (UCW+1)'(r_up) + (UCW+1)'(1);
    assign div_t    = {r_rem, r_dsh[31]};
    assign div_ge   = (div_t >= {1'b0, r_bsz});
    assign prev_end = {1'b0, r_pb} + {1'b0, r_pl};
    assign cur_end  = {1'b0, r_off} + {1'b0, r_len};
    assign ok       = (i_cmd.code == ST_OK);
    assign cfg_buf  = AW'(i_cfg_data);

    always_comb begin
        n_ftot = r_ftot;
        n_utot = r_utot;
        if (ok) begin
            if (!r_mode) begin
                n_ftot = r_ftot - r_real[31:0];
                n_utot = r_utot + r_real[31:0];
            end else begin
                n_ftot = r_ftot + 32'(r_len);
                n_utot = r_utot - 32'(r_len);
            end
        end
    end

    // status back to the sequencer
    always_comb begin
        o_stat.is_free   = r_mode;
        o_stat.bsz_zero  = (r_bsz == '0);
        o_stat.ufull     = (r_ucnt >= U_MAX);
        o_stat.div_last  = (r_dcnt == 5'd31);
        o_stat.f_more    = (r_fp < r_fcnt);
        o_stat.fit       = (CW'(r_fl) >= CW'(r_real));
        o_stat.exact     = (CW'(r_fl) == CW'(r_real));
        o_stat.le_off    = (r_fb <= r_off);
        o_stat.u_more    = (r_up < r_ucnt);
        o_stat.id_eq     = (r_uid == r_id);
        o_stat.zero_len  = (r_len == '0);
        o_stat.mp        = r_mp;
        o_stat.mn        = r_mn;
        o_stat.ffull     = (r_fcnt >= F_MAX);
        o_stat.fmv_more  = (fm_inc < (FCW+1)'(r_fcnt));
        o_stat.fins_more = (r_fm > r_fp);
        o_stat.umv_more  = (up_inc < (UCW+1)'(r_ucnt));
    end

    // free-range memory port selection
    always_comb begin
        f_we    = 1'b0;
        f_re    = 1'b0;
        f_waddr = r_fp[FIW-1:0];
        f_raddr = r_fp[FIW-1:0];
        f_wb    = r_fb;
        f_wl    = r_fl;
        if (i_cfg_we && (i_cfg_index == CFG_BUFFER_SIZE)) begin
            f_we    = 1'b1;
            f_waddr = '0;
            f_wb    = '0;
            f_wl    = cfg_buf;
        end else begin
            case (i_cmd.op)
                OP_FRD: begin
                    f_re = 1'b1;
                end
                OP_FRD_MV_UP: begin
                    f_re    = 1'b1;
                    f_raddr = fm_inc[FIW-1:0];
                end
                OP_FRD_MV_DN: begin
                    f_re    = 1'b1;
                    f_raddr = fm_dec[FIW-1:0];
                end
                OP_FWR_MV_DOWN, OP_FWR_MV_UP: begin
                    f_we    = 1'b1;
                    f_waddr = r_fm[FIW-1:0];
                end
                OP_FWR_SPLIT: begin
                    f_we = 1'b1;
                    f_wb = r_fb + AW'(r_real);
                    f_wl = r_fl - AW'(r_real);
                end
                OP_FWR_NEW: begin
                    f_we = 1'b1;
                    f_wb = r_off;
                    f_wl = r_len;
                end
                OP_FWR_MERGE: begin
                    f_we = 1'b1;
                    if (r_mp) begin
                        f_waddr = fp_dec[FIW-1:0];
                        f_wb    = r_pb;
                        f_wl    = r_pl + r_len + (r_mn ? r_fl : '0);
                    end else begin
                        f_wb = r_off;
                        f_wl = r_fl + r_len;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // allocation memory port selection
    always_comb begin
        u_we    = 1'b0;
        u_re    = 1'b0;
        u_waddr = r_up[UIW-1:0];
        u_raddr = r_up[UIW-1:0];
        u_wid   = r_uid;
        u_wb    = r_ub;
        u_wl    = r_ul;
        case (i_cmd.op)
            OP_URD: begin
                u_re = 1'b1;
            end
            OP_URD_NEXT: begin
                u_re    = 1'b1;
                u_raddr = up_inc[UIW-1:0];
            end
            OP_UWR_DOWN: begin
                u_we = 1'b1;
            end
            OP_UWR_NEW: begin
                u_we    = 1'b1;
                u_waddr = r_ucnt[UIW-1:0];
                u_wid   = r_next_id;
                u_wb    = r_goff;
                u_wl    = AW'(r_real);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (f_we) begin
            fb_mem[f_waddr] <= f_wb;
            fl_mem[f_waddr] <= f_wl;
        end
        if (f_re) begin
            r_fb <= fb_mem[f_raddr];
            r_fl <= fl_mem[f_raddr];
        end
        if (u_we) begin
            uid_mem[u_waddr] <= u_wid;
            ub_mem[u_waddr]  <= u_wb;
            ul_mem[u_waddr]  <= u_wl;
        end
        if (u_re) begin
            r_uid <= uid_mem[u_raddr];
            r_ub  <= ub_mem[u_raddr];
            r_ul  <= ul_mem[u_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bsz     <= '0;
            r_fcnt    <= '0;
            r_ucnt    <= '0;
            r_next_id <= '0;
            r_ftot    <= '0;
            r_utot    <= '0;
            r_done    <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BLOCK_SIZE: begin
                        r_bsz <= i_cfg_data[15:0];
                    end
                    CFG_BUFFER_SIZE: begin
                        r_fcnt    <= (cfg_buf != '0) ? FCW'(1) : '0;
                        r_ucnt    <= '0;
                        r_next_id <= '0;
                        r_ftot    <= 32'(cfg_buf);
                        r_utot    <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    r_mode <= i_mode;
                    r_req  <= i_req_size;
                    r_id   <= i_alloc_id;
                    r_dsh  <= i_req_size;
                    r_rem  <= '0;
                    r_dcnt <= '0;
                    r_fp   <= '0;
                    r_up   <= '0;
                end
                OP_DIV_STEP: begin
                    r_rem  <= div_ge ? 16'(div_t - {1'b0, r_bsz}) : div_t[15:0];
                    r_dsh  <= {r_dsh[30:0], 1'b0};
                    r_dcnt <= r_dcnt + 5'd1;
                end
                OP_ROUND: begin
                    // round up: add the distance to the next block boundary
                    if (r_rem == '0) begin
                        r_real <= {1'b0, r_req};
                    end else begin
                        r_real <= {1'b0, r_req} + {17'd0, r_bsz} - {17'd0, r_rem};
                    end
                end
                OP_FADV: begin
                    r_pb <= r_fb;
                    r_pl <= r_fl;
                    r_fp <= r_fp + FCW'(1);
                end
                OP_A_TAKE: begin
                    r_goff <= r_fb;
                    r_fm   <= r_fp;
                end
                OP_FWR_MV_DOWN: begin
                    r_fm <= r_fm + FCW'(1);
                end
                OP_FWR_MV_UP: begin
                    r_fm <= fm_dec;
                end
                OP_F_DEC: begin
                    r_fcnt <= r_fcnt - FCW'(1);
                end
                OP_F_INS_INIT: begin
                    r_fm <= r_fcnt;
                end
                OP_FWR_NEW: begin
                    r_fcnt <= r_fcnt + FCW'(1);
                end
                OP_EVAL: begin
                    r_mp <= (r_fp != '0) && (prev_end == {1'b0, r_off});
                    r_mn <= (r_fp < r_fcnt) && (cur_end == {1'b0, r_fb});
                end
                OP_FWR_MERGE: begin
                    r_fm <= r_fp;
                end
                OP_UADV, OP_UWR_DOWN: begin
                    r_up <= r_up + UCW'(1);
                end
                OP_U_LATCH: begin
                    r_off <= r_ub;
                    r_len <= r_ul;
                end
                OP_U_DEC: begin
                    r_ucnt <= r_ucnt - UCW'(1);
                end
                OP_UWR_NEW: begin
                    r_ucnt <= r_ucnt + UCW'(1);
                end
                OP_FIN: begin
                    r_done <= 1'b1;
                    r_ftot <= n_ftot;
                    r_utot <= n_utot;
                    if (ok && !r_mode) r_next_id <= r_next_id + 32'd1;
                end
                default: begin
                end
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_FIN) begin
            r_status <= i_cmd.code;
            if (!ok) begin
                r_gid   <= '0;
                r_goffs <= '0;
                r_gsz   <= '0;
            end else if (!r_mode) begin
                r_gid   <= r_next_id;
                r_goffs <= 32'(r_goff);
                r_gsz   <= r_real[31:0];
            end else begin
                r_gid   <= r_id;
                r_goffs <= 32'(r_off);
                r_gsz   <= 32'(r_len);
            end
        end
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_grant_id     = r_gid;
    assign o_grant_offset = r_goffs;
    assign o_grant_size   = r_gsz;
    assign o_free_bytes   = r_ftot;
    assign o_used_bytes   = r_utot;
    assign o_used_count   = 6'(r_ucnt);
    assign o_free_count   = 6'(r_fcnt);

endmodule

// ----- hdl/first_fit_block_allocator_unit.sv -----
// An allocate probes the free ranges in order, runs the remainder divide when block_size is
// nonzero and drops the range on an exact fit; a free probes the allocations and the lower
// free ranges, then merges or inserts a range; a zero-size free only drops the allocation.
// Throughput: one request at a time, start is taken only while busy is low; the receiver
// cannot stall. Reset: synchronous active-low, clears the control registers, counts and
// totals, no memory clearing pass. Needs ffba_pkg, ffba_ctrl, ffba_dp.
`include "first_fit_block_allocator_unit_defines.svh"
module first_fit_block_allocator_unit #(
    parameter int FREE_SLOTS = 32,
    parameter int USED_SLOTS = 32,
    parameter int ADDR_BITS  = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_mode,
    input  logic [31:0]                    i_req_size,
    input  logic [31:0]                    i_alloc_id,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ffba_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    output logic                           o_done,
    output logic [1:0]                     o_status,
    output logic [31:0]                    o_grant_id,
    output logic [31:0]                    o_grant_offset,
    output logic [31:0]                    o_grant_size,
    output logic [31:0]                    o_free_bytes,
    output logic [31:0]                    o_used_bytes,
    output logic [5:0]                     o_used_count,
    output logic [5:0]                     o_free_count
);
    import ffba_pkg::*;

    t_cmd     cmd;
    t_dp_stat stat;
    logic     cfg_we;
    logic     done_err;
    logic     grant_zero;

    assign o_cfg_ready = !busy;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign done_err    = o_done && (o_status != ST_OK);
    assign grant_zero  = (o_grant_size == '0) && (o_grant_offset == '0) && (o_grant_id == '0);

    ffba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    ffba_dp #(
        .FREE_SLOTS (FREE_SLOTS),
        .USED_SLOTS (USED_SLOTS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_mode         (i_mode),
        .i_req_size     (i_req_size),
        .i_alloc_id     (i_alloc_id),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_grant_id     (o_grant_id),
        .o_grant_offset (o_grant_offset),
        .o_grant_size   (o_grant_size),
        .o_free_bytes   (o_free_bytes),
        .o_used_bytes   (o_used_bytes),
        .o_used_count   (o_used_count),
        .o_free_count   (o_free_count)
    );

    `FFBA_ASSERT_NEXT(a_done_single, o_done, !o_done)
    `FFBA_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    `FFBA_ASSERT_IMPL(a_err_no_grant, done_err, grant_zero)

endmodule
